>>> hdl/token_scanner_defines.svh
`ifndef TOKEN_SCANNER_DEFINES_SVH
`define TOKEN_SCANNER_DEFINES_SVH

// Checks a condition against a consequence in the same cycle.
`define TSC_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Checks a condition against a consequence in the next cycle.
`define TSC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

>>> hdl/tsc_pkg.sv
package tsc_pkg;

	localparam int TSC_MAX_LEN = 32;
	localparam int TSC_LEN_W = 6;
	localparam int TSC_WIN = 6;
	localparam int TSC_Q_DEPTH = 4;
	localparam int TSC_NUM_KW = 11;

	// Token kinds.
	localparam logic [5:0] K_END = 6'd0;
	localparam logic [5:0] K_ERR = 6'd1;
	localparam logic [5:0] K_LPAR = 6'd2;
	localparam logic [5:0] K_RPAR = 6'd3;
	localparam logic [5:0] K_LBRACE = 6'd4;
	localparam logic [5:0] K_RBRACE = 6'd5;
	localparam logic [5:0] K_SEMI = 6'd6;
	localparam logic [5:0] K_COMMA = 6'd7;
	localparam logic [5:0] K_COLON = 6'd8;
	localparam logic [5:0] K_MUL = 6'd9;
	localparam logic [5:0] K_GT = 6'd10;
	localparam logic [5:0] K_LT = 6'd11;
	localparam logic [5:0] K_LE = 6'd12;
	localparam logic [5:0] K_NOT = 6'd13;
	localparam logic [5:0] K_NE = 6'd14;
	localparam logic [5:0] K_ASSIGN = 6'd15;
	localparam logic [5:0] K_EQ = 6'd16;
	localparam logic [5:0] K_PLUS = 6'd17;
	localparam logic [5:0] K_INC = 6'd18;
	localparam logic [5:0] K_OR = 6'd19;
	localparam logic [5:0] K_AND = 6'd20;
	localparam logic [5:0] K_CHAR_LIT = 6'd21;
	localparam logic [5:0] K_STR_LIT = 6'd22;
	localparam logic [5:0] K_IDENT = 6'd23;
	localparam logic [5:0] K_NUMBER = 6'd24;
	localparam logic [5:0] K_MINUS = 6'd25;
	localparam logic [5:0] K_KW_BASE = 6'd26;

	// Character codes.
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAR = 8'h28;
	localparam logic [7:0] CH_RPAR = 8'h29;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UZ = 8'h5A;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LZ = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_BAR = 8'h7C;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// Keywords, left-justified, first character in the top byte.
	localparam logic [47:0] KW_TEXT [TSC_NUM_KW] = '{
		{"int", 24'h0}, {"char", 16'h0}, {"if", 32'h0}, {"else", 16'h0},
		"switch", {"case", 16'h0}, {"while", 8'h0}, {"for", 24'h0},
		"return", {"in", 32'h0}, {"out", 24'h0}
	};
	localparam int KW_LEN [TSC_NUM_KW] = '{3, 4, 2, 4, 6, 4, 5, 3, 6, 2, 3};

	typedef enum logic [3:0] {
		M_IDLE, M_LT, M_NOT, M_EQ, M_PLUS, M_OR, M_AND,
		M_CQ, M_CCH, M_STR, M_ID, M_MINUS, M_NUM
	} mode_t;

	typedef enum logic [1:0] {
		B_IDLE, B_SEND, B_FETCH
	} back_state_t;

	typedef struct packed {
		logic [5:0] kind;
		logic is_val;
		logic [TSC_LEN_W-1:0] len;
		logic trunc;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic v0;
		logic v1;
		cmd_t c0;
		cmd_t c1;
	} q_push_t;

	typedef struct packed {
		logic hit;
		logic [5:0] kind;
	} kw_res_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= CH_UA) && (c <= CH_UZ)) || (c == CH_USCORE) ||
			((c >= CH_LA) && (c <= CH_LZ));
	endfunction

	function automatic cmd_t mk_plain(input logic [5:0] kind);
		cmd_t c;
		c = '0;
		c.kind = kind;
		return c;
	endfunction

	function automatic cmd_t mk_value(input logic [5:0] kind,
			input logic [TSC_LEN_W-1:0] len, input logic trunc);
		cmd_t c;
		c = '0;
		c.kind = kind;
		c.is_val = 1'b1;
		c.len = len;
		c.trunc = trunc;
		return c;
	endfunction

	// Compares the first bytes of a token against the keyword list.
	function automatic kw_res_t kw_lookup(input logic [47:0] word,
			input logic [TSC_LEN_W-1:0] len);
		kw_res_t r;
		logic [47:0] mask;
		r = '0;
		for (int k = 0; k < TSC_NUM_KW; k++) begin
			mask = 48'hFFFF_FFFF_FFFF << (8 * (TSC_WIN - KW_LEN[k]));
			if (!r.hit && (len == TSC_LEN_W'(KW_LEN[k])) &&
					(((word ^ KW_TEXT[k]) & mask) == '0)) begin
				r.hit = 1'b1;
				r.kind = K_KW_BASE + 6'(k);
			end
		end
		return r;
	endfunction

endpackage

>>> hdl/tsc_front.sv
module tsc_front import tsc_pkg::*; #(
	parameter int MAX_LEN = TSC_MAX_LEN,
	localparam int IDX_W = $clog2(MAX_LEN)
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] in_char,
	input logic end_mark,
	input logic q_room,
	output q_push_t push,
	input logic drain_done,
	input logic [IDX_W-1:0] rd_addr,
	output logic [7:0] rd_data
);

	mode_t mode_q, mode_d, mode_n;
	logic [TSC_LEN_W-1:0] len_q;
	logic ovf_q;
	logic [7:0] win_q [TSC_WIN];
	logic pend_q;
	logic app_pend_q;
	logic [7:0] store [MAX_LEN];
	logic [7:0] rd_data_q;

	logic accept;
	logic id_v, id_clear, id_start;
	logic [5:0] id_kind;
	mode_t id_mode;
	logic c0v, rescan, do_clear, do_append;
	cmd_t c0;
	logic st_start, st_clear, st_append;
	logic e0v, e1v;
	cmd_t e0, e1;
	logic val_busy;
	logic room_left;
	kw_res_t kw;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [7:0] wr_data;

	assign in_ready = q_room && !pend_q;
	assign accept = in_valid && in_ready;
	assign room_left = len_q < TSC_LEN_W'(MAX_LEN);
	assign kw = kw_lookup({win_q[0], win_q[1], win_q[2], win_q[3], win_q[4], win_q[5]},
		len_q);

	// Scan of the current character as if the mode were idle.
	always_comb begin
		id_v = 1'b0;
		id_kind = K_ERR;
		id_mode = M_IDLE;
		id_clear = 1'b0;
		id_start = 1'b0;
		if (end_mark) begin
			id_v = 1'b1;
			id_kind = K_END;
		end else begin
			unique case (in_char) inside
				CH_TAB, CH_NL, CH_SP: ;
				CH_LPAR: begin id_v = 1'b1; id_kind = K_LPAR; end
				CH_RPAR: begin id_v = 1'b1; id_kind = K_RPAR; end
				CH_LBRACE: begin id_v = 1'b1; id_kind = K_LBRACE; end
				CH_RBRACE: begin id_v = 1'b1; id_kind = K_RBRACE; end
				CH_SEMI: begin id_v = 1'b1; id_kind = K_SEMI; end
				CH_COMMA: begin id_v = 1'b1; id_kind = K_COMMA; end
				CH_DOT: begin id_v = 1'b1; id_kind = K_COLON; end
				CH_STAR: begin id_v = 1'b1; id_kind = K_MUL; end
				CH_GT: begin id_v = 1'b1; id_kind = K_GT; end
				CH_LT: id_mode = M_LT;
				CH_BANG: id_mode = M_NOT;
				CH_EQ: id_mode = M_EQ;
				CH_PLUS: id_mode = M_PLUS;
				CH_BAR: id_mode = M_OR;
				CH_AMP: id_mode = M_AND;
				CH_SQUOTE: begin id_mode = M_CQ; id_clear = 1'b1; end
				CH_DQUOTE: begin id_mode = M_STR; id_clear = 1'b1; end
				CH_MINUS: begin id_mode = M_MINUS; id_start = 1'b1; end
				default: begin
					if (is_letter(in_char)) begin
						id_mode = M_ID;
						id_start = 1'b1;
					end else if (is_digit(in_char)) begin
						id_mode = M_NUM;
						id_start = 1'b1;
					end else begin
						id_v = 1'b1;
						id_kind = K_ERR;
					end
				end
			endcase
		end
	end

	// Next mode and the token that the current mode finishes.
	always_comb begin
		mode_n = mode_q;
		c0v = 1'b0;
		c0 = mk_plain(K_ERR);
		rescan = 1'b0;
		do_clear = 1'b0;
		do_append = 1'b0;
		unique case (mode_q) inside
			M_LT, M_NOT, M_EQ, M_PLUS: begin
				c0v = 1'b1;
				if (!end_mark && (in_char == ((mode_q == M_PLUS) ? CH_PLUS : CH_EQ))) begin
					mode_n = M_IDLE;
					unique case (mode_q)
						M_LT: c0 = mk_plain(K_LE);
						M_NOT: c0 = mk_plain(K_NE);
						M_EQ: c0 = mk_plain(K_EQ);
						default: c0 = mk_plain(K_INC);
					endcase
				end else begin
					rescan = 1'b1;
					unique case (mode_q)
						M_LT: c0 = mk_plain(K_LT);
						M_NOT: c0 = mk_plain(K_NOT);
						M_EQ: c0 = mk_plain(K_ASSIGN);
						default: c0 = mk_plain(K_PLUS);
					endcase
				end
			end
			M_OR, M_AND: begin
				c0v = 1'b1;
				mode_n = M_IDLE;
				if (!end_mark && (in_char == ((mode_q == M_OR) ? CH_BAR : CH_AMP))) begin
					c0 = mk_plain((mode_q == M_OR) ? K_OR : K_AND);
				end else begin
					c0 = mk_plain(K_ERR);
					do_clear = 1'b1;
				end
			end
			M_CQ: begin
				if (end_mark || (in_char == CH_SQUOTE)) begin
					c0v = 1'b1;
					do_clear = 1'b1;
					mode_n = M_IDLE;
				end else begin
					do_append = 1'b1;
					mode_n = M_CCH;
				end
			end
			M_CCH: begin
				c0v = 1'b1;
				do_clear = 1'b1;
				mode_n = M_IDLE;
				if (!end_mark && (in_char == CH_SQUOTE)) begin
					c0 = mk_value(K_CHAR_LIT, len_q, ovf_q);
				end
			end
			M_STR: begin
				if (end_mark) begin
					c0v = 1'b1;
					do_clear = 1'b1;
					mode_n = M_IDLE;
				end else if (in_char == CH_DQUOTE) begin
					c0v = 1'b1;
					c0 = mk_value(K_STR_LIT, len_q, ovf_q);
					do_clear = 1'b1;
					mode_n = M_IDLE;
				end else begin
					do_append = 1'b1;
				end
			end
			M_ID: begin
				if (!end_mark && (is_letter(in_char) || is_digit(in_char))) begin
					do_append = 1'b1;
				end else begin
					c0v = 1'b1;
					c0 = (!ovf_q && kw.hit) ? mk_plain(kw.kind) :
						mk_value(K_IDENT, len_q, ovf_q);
					do_clear = 1'b1;
					rescan = 1'b1;
				end
			end
			M_MINUS: begin
				if (!end_mark && is_digit(in_char)) begin
					do_append = 1'b1;
					mode_n = M_NUM;
				end else begin
					c0v = 1'b1;
					c0 = mk_plain(K_MINUS);
					do_clear = 1'b1;
					rescan = 1'b1;
				end
			end
			M_NUM: begin
				if (!end_mark && is_digit(in_char)) begin
					do_append = 1'b1;
				end else begin
					c0v = 1'b1;
					c0 = mk_value(K_NUMBER, len_q, ovf_q);
					do_clear = 1'b1;
					rescan = 1'b1;
				end
			end
			default: rescan = 1'b1;
		endcase
		if (rescan) begin
			mode_n = id_mode;
		end
	end

	always_comb begin
		st_start = rescan && id_start;
		st_clear = do_clear || (rescan && id_clear);
		st_append = do_append;

		e0v = c0v || (rescan && id_v);
		e1v = c0v && rescan && id_v;
		e0 = c0v ? c0 : mk_plain(id_kind);
		e1 = mk_plain(id_kind);
		e0.last = !e1v;
		e1.last = 1'b1;

		push.v0 = accept && e0v;
		push.v1 = accept && e1v;
		push.c0 = e0;
		push.c1 = e1;

		// A value token still has to be read out of the store, so a new token's
		// first byte waits until the drain is over.
		val_busy = c0v && c0.is_val && (len_q != '0);

		mode_d = accept ? mode_n : mode_q;

		if (pend_q) begin
			wr_en = drain_done && app_pend_q;
			wr_addr = '0;
			wr_data = win_q[0];
		end else begin
			wr_en = accept && !val_busy && (st_start || (st_append && room_left));
			wr_addr = st_start ? '0 : len_q[IDX_W-1:0];
			wr_data = in_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			len_q <= '0;
			ovf_q <= 1'b0;
			pend_q <= 1'b0;
			app_pend_q <= 1'b0;
		end else begin
			mode_q <= mode_d;
			if (accept) begin
				if (st_start) begin
					len_q <= TSC_LEN_W'(1);
					ovf_q <= 1'b0;
				end else if (st_clear) begin
					len_q <= '0;
					ovf_q <= 1'b0;
				end else if (st_append) begin
					if (room_left) begin
						len_q <= len_q + 1'b1;
					end else begin
						ovf_q <= 1'b1;
					end
				end
			end
			if (accept && val_busy) begin
				pend_q <= 1'b1;
				app_pend_q <= st_start;
			end else if (drain_done) begin
				pend_q <= 1'b0;
				app_pend_q <= 1'b0;
			end
		end
	end

	// The first bytes of a token are also kept in flops for keyword matching.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (st_start) begin
				win_q[0] <= in_char;
			end else if (st_append && (len_q < TSC_LEN_W'(TSC_WIN))) begin
				win_q[len_q[$clog2(TSC_WIN)-1:0]] <= in_char;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store[wr_addr] <= wr_data;
		end
		rd_data_q <= store[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> hdl/tsc_queue.sv
`include "token_scanner_defines.svh"

module tsc_queue import tsc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input q_push_t push,
	output logic room,
	output logic head_valid,
	output cmd_t head,
	input logic pop
);

	localparam int DEPTH = TSC_Q_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] wr_ptr_1;

	assign wr_ptr_1 = wr_ptr_q + 1'b1;
	assign room = cnt_q <= CNT_W'(DEPTH - 2);
	assign head_valid = cnt_q != '0;
	assign head = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.v0) begin
			entries_q[wr_ptr_q] <= push.c0;
		end
		if (push.v1) begin
			entries_q[wr_ptr_1] <= push.c1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.v0) + PTR_W'(push.v1);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			cnt_q <= cnt_q + CNT_W'(push.v0) + CNT_W'(push.v1) - CNT_W'(pop);
		end
	end

	`TSC_ASSERT_IMP(a_push_room, push.v0, cnt_q <= CNT_W'(DEPTH - 2), "queue overrun")
	`TSC_ASSERT_IMP(a_pop_nonempty, pop, cnt_q != '0, "pop from empty queue")
	`TSC_ASSERT_IMP(a_pair_order, push.v1, push.v0, "second entry without first")

endmodule

>>> hdl/tsc_back.sv
`include "token_scanner_defines.svh"

module tsc_back import tsc_pkg::*; #(
	parameter int MAX_LEN = TSC_MAX_LEN,
	localparam int IDX_W = $clog2(MAX_LEN)
) (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input cmd_t head,
	output logic pop,
	output logic drain_done,
	output logic [IDX_W-1:0] rd_addr,
	input logic [7:0] rd_data,
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata,
	output logic [8:0] m_tuser,
	output logic m_tlast
);

	back_state_t state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	cmd_t cur_q, cur_d;
	logic ov_q;
	logic [5:0] o_kind_q;
	logic [7:0] o_byte_q;
	logic o_bv_q, o_done_q, o_trunc_q, o_last_q;

	logic out_free, fin, load;
	logic [5:0] ld_kind;
	logic [7:0] ld_byte;
	logic ld_bv, ld_done, ld_trunc, ld_last;

	assign out_free = !ov_q || m_tready;
	assign fin = (TSC_LEN_W'(idx_q) + 1'b1) == cur_q.len;
	assign rd_addr = idx_q;

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		cur_d = cur_q;
		pop = 1'b0;
		drain_done = 1'b0;
		load = 1'b0;
		ld_kind = cur_q.kind;
		ld_byte = '0;
		ld_bv = 1'b0;
		ld_done = 1'b1;
		ld_trunc = 1'b0;
		ld_last = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (head_valid && out_free) begin
					pop = 1'b1;
					if (head.is_val && (head.len != '0)) begin
						cur_d = head;
						state_d = B_SEND;
					end else begin
						load = 1'b1;
						ld_kind = head.kind;
						ld_trunc = head.trunc;
						ld_last = head.last;
					end
				end
			end
			B_SEND: begin
				if (out_free) begin
					load = 1'b1;
					ld_byte = rd_data;
					ld_bv = 1'b1;
					ld_done = fin;
					ld_trunc = cur_q.trunc;
					ld_last = fin && cur_q.last;
					if (fin) begin
						state_d = B_IDLE;
						idx_d = '0;
						drain_done = 1'b1;
					end else begin
						idx_d = idx_q + 1'b1;
						state_d = B_FETCH;
					end
				end
			end
			// The store read register has to take in the new address before the next byte is sent.
			B_FETCH: state_d = B_SEND;
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			idx_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			if (load) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		if (load) begin
			o_kind_q <= ld_kind;
			o_byte_q <= ld_byte;
			o_bv_q <= ld_bv;
			o_done_q <= ld_done;
			o_trunc_q <= ld_trunc;
			o_last_q <= ld_last;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata = o_byte_q;
	assign m_tuser = {o_trunc_q, o_done_q, o_bv_q, o_kind_q};
	assign m_tlast = o_last_q;

	`TSC_ASSERT_IMP(a_send_in_range, state_q == B_SEND, TSC_LEN_W'(idx_q) < cur_q.len,
		"store read beyond token length")
	`TSC_ASSERT_NEXT(a_done_to_idle, drain_done, state_q == B_IDLE, "drain did not finish")

endmodule

>>> hdl/token_scanner.sv
// Channel  Direction  tdata            tuser                               tlast
// s_*      in         in_char          end_mark                            -
// m_*      out        value_byte       token_kind, byte_valid,             last
//                                      token_done, value_truncated
//
// An input character is taken when the command queue has room for two entries.
// Plain tokens leave at one per cycle while the output is ready; a value token drains byte by byte
// through the single read port of the value store, and input is held off until its drain ends.
// Reset clears the scan mode, the token length, the queue pointers and the output valid flag; the
// value store itself is not cleared. A stalled output fills the queue, then stops input.
module token_scanner import tsc_pkg::*; #(
	parameter int MAX_LEN = TSC_MAX_LEN,
	localparam int IDX_W = $clog2(MAX_LEN)
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata,    // [7:0] in_char
	input logic s_tuser,          // [0] end_mark
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata,   // [7:0] value_byte
	output logic [8:0] m_tuser,   // [5:0] token_kind, [6] byte_valid, [7] token_done,
	                              // [8] value_truncated
	output logic m_tlast
);

	q_push_t push;
	logic q_room;
	logic head_valid;
	cmd_t head;
	logic pop;
	logic drain_done;
	logic [IDX_W-1:0] rd_addr;
	logic [7:0] rd_data;

	tsc_front #(.MAX_LEN(MAX_LEN)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_char(s_tdata),
		.end_mark(s_tuser),
		.q_room(q_room),
		.push(push),
		.drain_done(drain_done),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	tsc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(q_room),
		.head_valid(head_valid),
		.head(head),
		.pop(pop)
	);

	tsc_back #(.MAX_LEN(MAX_LEN)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.drain_done(drain_done),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

endmodule

>>> tb/token_scanner_tb.sv
module token_scanner_tb import tsc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 150;
	localparam int DRAIN_CYCLES = 64;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int DIR_N = 27;

	// One source character or end mark, with an optional hand-written single result.
	typedef struct packed {
		logic [7:0] ch;
		logic eom;
		logic typed;
		logic [5:0] kind;
	} scan_item_t;

	typedef struct packed {
		logic [5:0] kind;
		logic [7:0] val;
		logic bv;
		logic done;
		logic trunc;
		logic last;
	} tok_item_t;

	localparam string KEYWORDS [TSC_NUM_KW] = '{
		"int", "char", "if", "else", "switch", "case", "while", "for", "return", "in", "out"
	};
	localparam logic [7:0] PUNCT [9] = '{
		CH_LPAR, CH_RPAR, CH_LBRACE, CH_RBRACE, CH_SEMI, CH_COMMA, CH_DOT, CH_STAR, CH_GT
	};
	localparam logic [7:0] OP_FIRST [6] = '{CH_LT, CH_BANG, CH_EQ, CH_PLUS, CH_BAR, CH_AMP};
	localparam logic [7:0] OP_SECOND [6] = '{CH_EQ, CH_EQ, CH_EQ, CH_PLUS, CH_BAR, CH_AMP};
	localparam logic [7:0] BLANKS [3] = '{CH_TAB, CH_NL, CH_SP};

	// The kind column only counts on rows whose typed bit is set.
	localparam scan_item_t DIRECTED [DIR_N] = '{
		'{8'h00, 1'b1, 1'b1, K_END},
		'{8'h00, 1'b0, 1'b1, K_ERR},
		'{8'hFF, 1'b0, 1'b1, K_ERR},
		'{CH_BAR, 1'b0, 1'b0, K_END},
		'{CH_LA, 1'b0, 1'b1, K_ERR},
		'{CH_AMP, 1'b0, 1'b0, K_END},
		'{8'hFF, 1'b1, 1'b1, K_ERR},
		'{CH_SQUOTE, 1'b0, 1'b0, K_END},
		'{CH_SQUOTE, 1'b0, 1'b1, K_ERR},
		'{CH_DQUOTE, 1'b0, 1'b0, K_END},
		'{8'h5A, 1'b1, 1'b1, K_ERR},
		'{CH_DQUOTE, 1'b0, 1'b0, K_END},
		'{CH_DQUOTE, 1'b0, 1'b1, K_STR_LIT},
		'{CH_LT, 1'b0, 1'b0, K_END},
		'{CH_EQ, 1'b0, 1'b1, K_LE},
		'{CH_MINUS, 1'b0, 1'b0, K_END},
		'{CH_9, 1'b0, 1'b0, K_END},
		'{8'h00, 1'b1, 1'b0, K_END},
		'{"i", 1'b0, 1'b0, K_END},
		'{"f", 1'b0, 1'b0, K_END},
		'{CH_TAB, 1'b0, 1'b0, K_END},
		'{CH_SQUOTE, 1'b0, 1'b0, K_END},
		'{8'hFF, 1'b0, 1'b0, K_END},
		'{CH_SQUOTE, 1'b0, 1'b0, K_END},
		'{CH_PLUS, 1'b0, 1'b0, K_END},
		'{CH_PLUS, 1'b0, 1'b1, K_INC},
		'{CH_STAR, 1'b0, 1'b1, K_MUL}
	};

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;    // [7:0] in_char
	logic s_tuser = 1'b0;           // [0] end_mark
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;            // [7:0] value_byte
	logic [8:0] m_tuser;            // [5:0] token_kind, [6] byte_valid, [7] token_done,
	                                // [8] value_truncated
	logic m_tlast;

	token_scanner uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Scanner state as the predictor sees it.
	mode_t lex_mode;
	logic [7:0] lex_store [TSC_MAX_LEN];
	int lex_len;
	bit lex_ovf;

	tok_item_t step_tokens[$];
	tok_item_t pending_tokens[$];
	scan_item_t feed[$];
	int mismatch_count = 0;
	int unsigned cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic note_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("%0t ns mismatch: %s", $realtime, what);
	endtask

	function automatic bit char_alpha(input logic [7:0] c);
		return (c >= CH_UA && c <= CH_UZ) || c == CH_USCORE || (c >= CH_LA && c <= CH_LZ);
	endfunction

	function automatic bit char_digit(input logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic void push_token(input logic [5:0] kind, input logic [7:0] val,
			input logic bv, input logic done, input logic trunc);
		tok_item_t t;
		t.kind = kind;
		t.val = val;
		t.bv = bv;
		t.done = done;
		t.trunc = trunc;
		t.last = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic void push_plain(input logic [5:0] kind);
		push_token(kind, 8'h00, 1'b0, 1'b1, 1'b0);
	endfunction

	function automatic void clear_value();
		lex_len = 0;
		lex_ovf = 1'b0;
	endfunction

	function automatic void store_byte(input logic [7:0] c);
		if (lex_len < TSC_MAX_LEN) begin
			lex_store[lex_len] = c;
			lex_len++;
		end else begin
			lex_ovf = 1'b1;
		end
	endfunction

	function automatic void emit_value(input logic [5:0] kind);
		if (lex_len == 0) begin
			push_token(kind, 8'h00, 1'b0, 1'b1, lex_ovf);
		end else begin
			for (int i = 0; i < lex_len; i++)
				push_token(kind, lex_store[i], 1'b1, i + 1 == lex_len, lex_ovf);
		end
		clear_value();
	endfunction

	function automatic void scan_error();
		clear_value();
		lex_mode = M_IDLE;
		push_plain(K_ERR);
	endfunction

	function automatic void idle_scan(input logic [7:0] c, input logic e);
		lex_mode = M_IDLE;
		if (e) begin
			push_plain(K_END);
		end else begin
			case (c) inside
				CH_TAB, CH_NL, CH_SP: ;
				CH_LPAR: push_plain(K_LPAR);
				CH_RPAR: push_plain(K_RPAR);
				CH_LBRACE: push_plain(K_LBRACE);
				CH_RBRACE: push_plain(K_RBRACE);
				CH_SEMI: push_plain(K_SEMI);
				CH_COMMA: push_plain(K_COMMA);
				CH_DOT: push_plain(K_COLON);
				CH_STAR: push_plain(K_MUL);
				CH_GT: push_plain(K_GT);
				CH_LT: lex_mode = M_LT;
				CH_BANG: lex_mode = M_NOT;
				CH_EQ: lex_mode = M_EQ;
				CH_PLUS: lex_mode = M_PLUS;
				CH_BAR: lex_mode = M_OR;
				CH_AMP: lex_mode = M_AND;
				CH_SQUOTE: begin
					clear_value();
					lex_mode = M_CQ;
				end
				CH_DQUOTE: begin
					clear_value();
					lex_mode = M_STR;
				end
				CH_MINUS: begin
					clear_value();
					store_byte(c);
					lex_mode = M_MINUS;
				end
				default: begin
					if (char_alpha(c)) begin
						clear_value();
						store_byte(c);
						lex_mode = M_ID;
					end else if (char_digit(c)) begin
						clear_value();
						store_byte(c);
						lex_mode = M_NUM;
					end else begin
						push_plain(K_ERR);
					end
				end
			endcase
		end
	endfunction

	function automatic void pair_or_single(input logic [7:0] c, input logic e,
			input logic [7:0] second, input logic [5:0] single, input logic [5:0] both);
		if (!e && c == second) begin
			lex_mode = M_IDLE;
			push_plain(both);
		end else begin
			push_plain(single);
			idle_scan(c, e);
		end
	endfunction

	// A truncated identifier never matches a keyword.
	function automatic void close_ident();
		bit hit;
		int kw;
		hit = 1'b0;
		kw = 0;
		if (!lex_ovf) begin
			for (int k = 0; k < TSC_NUM_KW && !hit; k++) begin
				if (KEYWORDS[k].len() == lex_len) begin
					hit = 1'b1;
					for (int i = 0; i < lex_len; i++)
						if (lex_store[i] != KEYWORDS[k][i])
							hit = 1'b0;
					if (hit)
						kw = k;
				end
			end
		end
		if (hit) begin
			clear_value();
			push_plain(K_KW_BASE + 6'(kw));
		end else begin
			emit_value(K_IDENT);
		end
	endfunction

	function automatic void lex_predict(input logic [7:0] c, input logic e);
		step_tokens.delete();
		case (lex_mode)
			M_LT: pair_or_single(c, e, CH_EQ, K_LT, K_LE);
			M_NOT: pair_or_single(c, e, CH_EQ, K_NOT, K_NE);
			M_EQ: pair_or_single(c, e, CH_EQ, K_ASSIGN, K_EQ);
			M_PLUS: pair_or_single(c, e, CH_PLUS, K_PLUS, K_INC);
			M_OR: begin
				if (!e && c == CH_BAR) begin
					lex_mode = M_IDLE;
					push_plain(K_OR);
				end else begin
					scan_error();
				end
			end
			M_AND: begin
				if (!e && c == CH_AMP) begin
					lex_mode = M_IDLE;
					push_plain(K_AND);
				end else begin
					scan_error();
				end
			end
			M_CQ: begin
				if (e || c == CH_SQUOTE) begin
					scan_error();
				end else begin
					store_byte(c);
					lex_mode = M_CCH;
				end
			end
			M_CCH: begin
				if (!e && c == CH_SQUOTE) begin
					lex_mode = M_IDLE;
					emit_value(K_CHAR_LIT);
				end else begin
					scan_error();
				end
			end
			M_STR: begin
				if (e) begin
					scan_error();
				end else if (c == CH_DQUOTE) begin
					lex_mode = M_IDLE;
					emit_value(K_STR_LIT);
				end else begin
					store_byte(c);
				end
			end
			M_ID: begin
				if (!e && (char_alpha(c) || char_digit(c))) begin
					store_byte(c);
				end else begin
					close_ident();
					idle_scan(c, e);
				end
			end
			M_MINUS: begin
				if (!e && char_digit(c)) begin
					store_byte(c);
					lex_mode = M_NUM;
				end else begin
					clear_value();
					push_plain(K_MINUS);
					idle_scan(c, e);
				end
			end
			M_NUM: begin
				if (!e && char_digit(c)) begin
					store_byte(c);
				end else begin
					emit_value(K_NUMBER);
					idle_scan(c, e);
				end
			end
			default: idle_scan(c, e);
		endcase
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].last = 1'b1;
	endfunction

	function automatic void add_char(input logic [7:0] c);
		feed.push_back('{c, 1'b0, 1'b0, K_END});
	endfunction

	function automatic void add_end(input logic [7:0] c);
		feed.push_back('{c, 1'b1, 1'b0, K_END});
	endfunction

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26)
			return CH_UA + 8'(r);
		else if (r < 52)
			return CH_LA + 8'(r - 26);
		return CH_USCORE;
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_0 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] any_but(input logic [7:0] q);
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == q);
		return c;
	endfunction

	// Mostly short values, now and then one around the store length to hit truncation.
	function automatic int rand_len(input int lo, input int hi);
		if ($urandom_range(0, 11) == 0)
			return $urandom_range(TSC_MAX_LEN - 2, TSC_MAX_LEN + 5);
		return $urandom_range(lo, hi);
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("token_scanner verification failed");
			$finish;
		end
	end

	// Output side: the ready pattern changes its character after each span of random length.
	initial begin : ready_pattern
		int style;
		int span;
		forever begin
			style = $urandom_range(0, 3);
			span = (style == 3) ? $urandom_range(4, 24) : $urandom_range(8, 64);
			repeat (span) begin
				@(posedge clk);
				case (style)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= 1'b0;
				endcase
			end
		end
	end

	always @(posedge clk) begin : token_check
		tok_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_tokens.size() == 0) begin
				note_mismatch($sformatf("unexpected transfer kind %0d byte %02h",
					m_tuser[5:0], m_tdata));
			end else begin
				want = pending_tokens.pop_front();
				if (m_tuser[5:0] !== want.kind)
					note_mismatch($sformatf("token_kind %0d, want %0d", m_tuser[5:0], want.kind));
				if (m_tdata !== want.val)
					note_mismatch($sformatf("value_byte %02h, want %02h", m_tdata, want.val));
				if (m_tuser[6] !== want.bv)
					note_mismatch($sformatf("byte_valid %b, want %b", m_tuser[6], want.bv));
				if (m_tuser[7] !== want.done)
					note_mismatch($sformatf("token_done %b, want %b", m_tuser[7], want.done));
				if (m_tuser[8] !== want.trunc)
					note_mismatch($sformatf("value_truncated %b, want %b", m_tuser[8],
						want.trunc));
				if (m_tlast !== want.last)
					note_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
			end
		end
	end

	initial begin : source_feed
		scan_item_t it;
		tok_item_t typed_tok;
		int burst;
		int gap;
		int pick;
		int len;

		lex_mode = M_IDLE;
		lex_len = 0;
		lex_ovf = 1'b0;
		foreach (DIRECTED[i])
			feed.push_back(DIRECTED[i]);

		// Random part: mostly well-formed tokens with random content, with some noise.
		while (feed.size() < DIR_N + RANDOM_ITEMS) begin
			case ($urandom_range(0, 19)) inside
				0, 1: add_char(PUNCT[$urandom_range(0, 8)]);
				2, 3: begin
					pick = $urandom_range(0, 5);
					add_char(OP_FIRST[pick]);
					if ($urandom_range(0, 1))
						add_char(OP_SECOND[pick]);
				end
				4, 5, 6: begin
					len = rand_len(1, 8);
					add_char(rand_letter());
					for (int i = 1; i < len; i++)
						add_char(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter());
				end
				7, 8: begin
					pick = $urandom_range(0, TSC_NUM_KW - 1);
					for (int i = 0; i < KEYWORDS[pick].len(); i++)
						add_char(KEYWORDS[pick][i]);
					if ($urandom_range(0, 3) == 0)
						add_char(rand_letter());
				end
				9, 10: begin
					if ($urandom_range(0, 1))
						add_char(CH_MINUS);
					len = rand_len(1, 6);
					repeat (len) add_char(rand_digit());
				end
				11: begin
					add_char(CH_SQUOTE);
					case ($urandom_range(0, 7))
						0: add_char(CH_SQUOTE);
						1: add_end(8'($urandom_range(0, 255)));
						2: begin
							add_char(any_but(CH_SQUOTE));
							add_end(8'($urandom_range(0, 255)));
						end
						3: begin
							add_char(any_but(CH_SQUOTE));
							add_char(any_but(CH_SQUOTE));
						end
						default: begin
							add_char(any_but(CH_SQUOTE));
							add_char(CH_SQUOTE);
						end
					endcase
				end
				12: begin
					add_char(CH_DQUOTE);
					len = rand_len(0, 10);
					repeat (len) add_char(any_but(CH_DQUOTE));
					if ($urandom_range(0, 7) == 0)
						add_end(8'($urandom_range(0, 255)));
					else
						add_char(CH_DQUOTE);
				end
				13: add_char(CH_MINUS);
				14, 15: repeat ($urandom_range(1, 3)) add_char(BLANKS[$urandom_range(0, 2)]);
				16: add_char(8'($urandom_range(0, 255)));
				17: add_end(8'($urandom_range(0, 255)));
				default: add_char(CH_SP);
			endcase
		end
		add_end(8'($urandom_range(0, 255)));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		burst = 0;
		foreach (feed[n]) begin
			it = feed[n];
			if (burst == 0) begin
				burst = $urandom_range(1, 12);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			s_tvalid <= 1'b1;
			s_tdata <= it.ch;
			s_tuser <= it.eom;
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			// The transfer has been taken at this edge.
			lex_predict(it.ch, it.eom);
			if (it.typed) begin
				typed_tok = '{it.kind, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1};
				pending_tokens.push_back(typed_tok);
			end else begin
				foreach (step_tokens[k])
					pending_tokens.push_back(step_tokens[k]);
			end
			burst--;
		end
		s_tvalid <= 1'b0;

		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_tokens.size() != 0)
			note_mismatch($sformatf("%0d tokens never arrived", pending_tokens.size()));

		if (mismatch_count == 0)
			$display("token_scanner verification clean");
		else
			$display("token_scanner verification failed");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hdl
hdl/tsc_pkg.sv
hdl/tsc_front.sv
hdl/tsc_queue.sv
hdl/tsc_back.sv
hdl/token_scanner.sv
tb/token_scanner_tb.sv
